FILE: sv/mbe_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared widths, fixed-point constants, controller states and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mbe_pkg;

	// Input points are signed Q4.28; the iterate z is held as signed Q8.28.
	localparam int FRAC_BITS = 28;
	localparam int IN_W      = 32;
	localparam int Z_W       = FRAC_BITS + 8;
	localparam int HALF_W    = Z_W / 2;
	localparam int PROD_W    = Z_W + HALF_W;
	localparam int ACC_W     = 2 * Z_W;
	localparam int ITER_W    = 16;
	localparam int CFG_W     = 16;
	localparam int COLOR_W   = 8;

	localparam logic [ITER_W-1:0]  DEPTH_RESET = ITER_W'(10000);
	localparam logic [COLOR_W-1:0] COLOR_MAX   = COLOR_W'(255);
	localparam logic [COLOR_W-1:0] COLOR_WRAP  = COLOR_W'(254);

	localparam logic signed [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
	localparam logic signed [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};
	localparam logic signed [Z_W-1:0] FOUR  = Z_W'(4) << FRAC_BITS;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ROUND,
		ST_UPDATE,
		ST_DONE
	} state_t;

	// Which product the shared multiplier is working on.
	typedef enum logic [1:0] {
		SEL_XX,
		SEL_YY,
		SEL_XY
	} sel_t;

	typedef struct packed {
		logic load;
		logic mul_lo;
		logic mul_hi;
		logic round;
		logic update;
		logic out_load;
		sel_t sel;
	} cmd_t;

	typedef struct packed {
		logic depth_zero;
		logic escaped;
		logic last_pass;
		logic out_free;
	} sts_t;

endpackage

FILE: sv/mandelbrot_escape_time_core.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time core
// Iterates z = z^2 + c from zero for one point c per input beat and returns
// the escape pass modulo 255, or 255 when the point stays bounded.
//
//   channel | direction | tdata / wdata fields (low bit first)
//   s_      | in        | c_real[31:0], c_imag[63:32], signed Q4.28
//   m_      | out       | color_index[7:0]
//   cfg_    | in        | max_iterations[15:0], write on cfg_we
//
// For each item, one shared 36 x 18 multiplier forms the three products of each
// pass as a low half, a high half and a rounding step, plus one update of z.
// Passes are bounded by max_iterations, which resets to 10000.
// Reset is asynchronous and active low; no clearing pass is needed.
// A result waits in the output register; the core then takes the next point,
// but holds its own result until the output register is free.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [2*mbe_pkg::IN_W-1:0]        s_tdata,   // c_real, c_imag
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mbe_pkg::COLOR_W-1:0]       m_tdata,   // color_index
	input  logic                              cfg_we,
	input  logic [mbe_pkg::CFG_W-1:0]         cfg_wdata  // max_iterations
);
	import mbe_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	mbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Arithmetic, counters and output register.
	mbe_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

FILE: sv/mbe_ctrl.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time controller
// Steps the shared multiplier through the three products of each pass,
// then the update of z, and hands the finished result to the output stage.
// ----------------------------------------------------------------------------
module mbe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  mbe_pkg::sts_t sts,
	output mbe_pkg::cmd_t cmd
);
	import mbe_pkg::*;

	state_t state_q;
	state_t state_d;
	sel_t   sel_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = sts.depth_zero ? ST_DONE : ST_MUL_LO;
				end
			end
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_ROUND;
			ST_ROUND: begin
				state_d = (sel_q == SEL_XY) ? ST_UPDATE : ST_MUL_LO;
			end
			ST_UPDATE: begin
				state_d = (sts.escaped || sts.last_pass) ? ST_DONE : ST_MUL_LO;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd          = '0;
		cmd.sel      = sel_q;
		s_tready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_MUL_LO: cmd.mul_lo = 1'b1;
			ST_MUL_HI: cmd.mul_hi = 1'b1;
			ST_ROUND:  cmd.round  = 1'b1;
			ST_UPDATE: cmd.update = 1'b1;
			ST_DONE:   cmd.out_load = sts.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State and product selector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= SEL_XX;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ROUND) begin
				case (sel_q)
					SEL_XX:  sel_q <= SEL_YY;
					SEL_YY:  sel_q <= SEL_XY;
					default: sel_q <= SEL_XX;
				endcase
			end else if (state_q == ST_IDLE) begin
				sel_q <= SEL_XX;
			end
		end
	end

endmodule

FILE: sv/mbe_datapath.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time datapath
// Holds c, z, the depth register and the pass counters, one shared
// 36 x 18 multiplier with its accumulator, and the output register.
// ----------------------------------------------------------------------------
module mbe_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mbe_pkg::cmd_t                       cmd,
	output mbe_pkg::sts_t                       sts,
	input  logic [2*mbe_pkg::IN_W-1:0]          s_tdata,
	input  logic                                cfg_we,
	input  logic [mbe_pkg::CFG_W-1:0]           cfg_wdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [mbe_pkg::COLOR_W-1:0]         m_tdata
);
	import mbe_pkg::*;

	logic [ITER_W-1:0]        max_iter_q;
	logic signed [Z_W-1:0]    a_q, b_q, x_q, y_q;
	logic signed [Z_W-1:0]    x2_q, y2_q, xy2_q;
	logic [ACC_W-1:0]         acc_q;
	logic                     neg_q;
	logic [ITER_W-1:0]        iter_q;
	logic [COLOR_W-1:0]       mod_q;
	logic [COLOR_W-1:0]       res_q;
	logic [COLOR_W-1:0]       color_q;
	logic                     out_valid_q;

	logic [IN_W-1:0]          c_real, c_imag;
	logic [Z_W-1:0]           opa, opb, ua, ub;
	logic [HALF_W-1:0]        ub_part;
	logic [PROD_W-1:0]        prod;
	logic [ACC_W-1:0]         qf;
	logic                     rem_nz;
	logic [Z_W:0]             q1;
	logic signed [Z_W-1:0]    rounded;
	logic signed [Z_W+1:0]    sum_x, sum_y, mag;
	logic signed [Z_W-1:0]    next_x, next_y;
	logic                     escaped;

	function automatic logic signed [Z_W+1:0] sext2(input logic signed [Z_W-1:0] v);
		sext2 = signed'({{2{v[Z_W-1]}}, v});
	endfunction

	function automatic logic signed [Z_W-1:0] sat_z(input logic signed [Z_W+1:0] v);
		if (v > sext2(Z_MAX)) begin
			sat_z = Z_MAX;
		end else if (v < sext2(Z_MIN)) begin
			sat_z = Z_MIN;
		end else begin
			sat_z = v[Z_W-1:0];
		end
	endfunction

	assign c_real = s_tdata[IN_W-1:0];
	assign c_imag = s_tdata[2*IN_W-1:IN_W];

	// Operand selection and magnitudes for the unsigned multiplier.
	always_comb begin
		case (cmd.sel)
			SEL_XX: begin
				opa = x_q;
				opb = x_q;
			end
			SEL_YY: begin
				opa = y_q;
				opb = y_q;
			end
			default: begin
				opa = x_q;
				opb = y_q;
			end
		endcase
	end

	assign ua      = opa[Z_W-1] ? (~opa + Z_W'(1)) : opa;
	assign ub      = opb[Z_W-1] ? (~opb + Z_W'(1)) : opb;
	assign ub_part = cmd.mul_hi ? ub[Z_W-1:HALF_W] : ub[HALF_W-1:0];
	assign prod    = PROD_W'(ua) * PROD_W'(ub_part);

	// Truncate the product toward minus infinity and saturate. The cross
	// product is doubled by shifting one bit less.
	always_comb begin
		if (cmd.sel == SEL_XY) begin
			qf     = acc_q >> (FRAC_BITS - 1);
			rem_nz = |acc_q[FRAC_BITS-2:0];
		end else begin
			qf     = acc_q >> FRAC_BITS;
			rem_nz = |acc_q[FRAC_BITS-1:0];
		end
		q1 = {1'b0, qf[Z_W-1:0]} + (Z_W+1)'(rem_nz);
		if (!neg_q) begin
			rounded = (|qf[ACC_W-1:Z_W-1]) ? Z_MAX : signed'(qf[Z_W-1:0]);
		end else if ((|qf[ACC_W-1:Z_W]) || (|q1[Z_W:Z_W-1])) begin
			rounded = Z_MIN;
		end else begin
			rounded = signed'(~q1[Z_W-1:0] + Z_W'(1));
		end
	end

	// New z and the escape test on the old squares.
	assign sum_x   = sext2(x2_q) - sext2(y2_q) + sext2(a_q);
	assign sum_y   = sext2(xy2_q) + sext2(b_q);
	assign next_x  = sat_z(sum_x);
	assign next_y  = sat_z(sum_y);
	assign mag     = sext2(x2_q) + sext2(y2_q);
	assign escaped = mag > sext2(FOUR);

	assign sts.depth_zero = (max_iter_q == '0);
	assign sts.escaped    = escaped;
	assign sts.last_pass  = ((iter_q + ITER_W'(1)) == max_iter_q);
	assign sts.out_free   = !out_valid_q || m_tready;

	// Control registers: depth and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q  <= DEPTH_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_iter_q <= cfg_wdata[ITER_W-1:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q    <= signed'({{(Z_W-IN_W){c_real[IN_W-1]}}, c_real});
			b_q    <= signed'({{(Z_W-IN_W){c_imag[IN_W-1]}}, c_imag});
			x_q    <= '0;
			y_q    <= '0;
			iter_q <= '0;
			mod_q  <= '0;
			res_q  <= COLOR_MAX;
		end
		if (cmd.mul_lo) begin
			acc_q <= ACC_W'(prod);
			neg_q <= opa[Z_W-1] ^ opb[Z_W-1];
		end
		if (cmd.mul_hi) begin
			acc_q <= acc_q + (ACC_W'(prod) << HALF_W);
		end
		if (cmd.round) begin
			case (cmd.sel)
				SEL_XX:  x2_q  <= rounded;
				SEL_YY:  y2_q  <= rounded;
				default: xy2_q <= rounded;
			endcase
		end
		if (cmd.update) begin
			x_q    <= next_x;
			y_q    <= next_y;
			iter_q <= iter_q + ITER_W'(1);
			mod_q  <= (mod_q == COLOR_WRAP) ? '0 : mod_q + COLOR_W'(1);
			if (escaped) begin
				res_q <= mod_q;
			end
		end
		if (cmd.out_load) begin
			color_q <= res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = color_q;

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time core testbench
// Streams complex points into the core and checks each returned colour index
// against an in-bench fixed-point escape-time predictor. Directed points cover
// the Q4.28 extremes, the zero, maximum and reset depths, periodic orbits and
// escapes past the 255 wrap. Random points then run under several depth
// settings, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module testbench;

	localparam int     CLOCK_PERIOD  = 10;
	localparam longint CYCLE_LIMIT   = 4_000_000;
	localparam int     SETTLE_CYCLES = 16;
	localparam int     POINTS_PER_PHASE = 175;
	localparam int     FB            = mbe_pkg::FRAC_BITS;
	localparam longint Z_HIGH = (longint'(1) <<< (mbe_pkg::Z_W - 1)) - 1;
	localparam longint Z_LOW  = -(longint'(1) <<< (mbe_pkg::Z_W - 1));
	localparam longint RADIUS_SQ = longint'(4) <<< FB;

	// A few Q4.28 values used by the directed points.
	localparam logic [31:0] Q_ZERO    = 32'h0000_0000;
	localparam logic [31:0] Q_ONE     = 32'h1000_0000;
	localparam logic [31:0] Q_TWO     = 32'h2000_0000;
	localparam logic [31:0] Q_NEG_ONE = 32'hF000_0000;
	localparam logic [31:0] Q_NEG_TWO = 32'hE000_0000;
	localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN     = 32'h8000_0000;
	localparam logic [31:0] Q_QUARTER = 32'h0400_0000;
	localparam logic [31:0] Q_NEG_3Q  = 32'hF400_0000;
	localparam logic [31:0] Q_0P3     = 32'h04CC_CCCD;
	localparam logic [31:0] Q_0P1     = 32'h0199_999A;
	localparam logic [31:0] Q_0P01    = 32'h0028_F5C3;

	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                s_tvalid  = 1'b0;
	logic                                s_tready;
	logic [2*mbe_pkg::IN_W-1:0]          s_tdata   = '0;   // c_real, c_imag
	logic                                m_tvalid;
	logic                                m_tready  = 1'b0;
	logic [mbe_pkg::COLOR_W-1:0]         m_tdata;          // color_index
	logic                                cfg_we    = 1'b0;
	logic [mbe_pkg::CFG_W-1:0]           cfg_wdata = '0;   // max_iterations

	// Points waiting to be sent, colours waiting to come back.
	logic [2*mbe_pkg::IN_W-1:0]  pending_points[$];
	logic [mbe_pkg::COLOR_W-1:0] expected_colors[$];

	logic [mbe_pkg::CFG_W-1:0] depth_setting = mbe_pkg::DEPTH_RESET;
	bit                        stalls_enabled = 1'b1;
	bit                        point_held = 1'b0;
	int unsigned               mismatch_count = 0;
	longint                    cycle_count = 0;

	mandelbrot_escape_time_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #(CLOCK_PERIOD / 2) clk = ~clk;
	end

	// Exact product shifted down with rounding toward minus infinity, then
	// saturated to the Q8.F range of the iterate.
	function automatic longint product_floor(longint m, longint n, int sh);
		logic signed [127:0] wm;
		logic signed [127:0] wn;
		logic signed [127:0] wide;
		wm = m;
		wn = n;
		wide = (wm * wn) >>> sh;
		if (wide > Z_HIGH) return Z_HIGH;
		if (wide < Z_LOW) return Z_LOW;
		return longint'(wide);
	endfunction

	function automatic longint clamp_z(longint v);
		if (v > Z_HIGH) return Z_HIGH;
		if (v < Z_LOW) return Z_LOW;
		return v;
	endfunction

	// Escape-time colour of one point at the given depth.
	function automatic logic [mbe_pkg::COLOR_W-1:0] escape_color(
		logic [2*mbe_pkg::IN_W-1:0] beat, logic [mbe_pkg::CFG_W-1:0] depth);
		longint      a;
		longint      b;
		longint      x;
		longint      y;
		longint      x2;
		longint      y2;
		longint      xy2;
		int unsigned pass_no;
		a = longint'($signed(beat[31:0]));
		b = longint'($signed(beat[63:32]));
		// Align Q4.28 inputs to the internal fraction width.
		if (FB >= 28) begin
			a = a <<< (FB - 28);
			b = b <<< (FB - 28);
		end else begin
			a = a >>> (28 - FB);
			b = b >>> (28 - FB);
		end
		x = 0;
		y = 0;
		for (pass_no = 0; pass_no < depth; pass_no++) begin
			x2  = product_floor(x, x, FB);
			y2  = product_floor(y, y, FB);
			xy2 = product_floor(x, y, FB - 1);
			x   = clamp_z(x2 - y2 + a);
			y   = clamp_z(xy2 + b);
			// The escape test looks at the previous iterate's squares.
			if (x2 + y2 > RADIUS_SQ) return mbe_pkg::COLOR_W'(pass_no % 255);
		end
		return mbe_pkg::COLOR_MAX;
	endfunction

	// Stimulus driver: both sides change at the falling edge. A point that
	// has been offered stays on the bus until the core accepts it.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!point_held) begin
				if (pending_points.size() > 0 &&
					!(stalls_enabled && $urandom_range(99, 0) < 8)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_points[0];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= !(stalls_enabled && $urandom_range(99, 0) < 8);
		end
	end

	// Monitor: predicts on each accepted point, checks each colour beat.
	always @(posedge clk) begin : monitor
		logic [mbe_pkg::COLOR_W-1:0] want;
		if (arst_n) begin
			point_held = s_tvalid && !s_tready;
			if (s_tvalid && s_tready) begin
				expected_colors.push_back(escape_color(s_tdata, depth_setting));
				void'(pending_points.pop_front());
			end
			if (m_tvalid && m_tready) begin
				if (expected_colors.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected colour beat: got %0d", m_tdata);
				end else begin
					want = expected_colors.pop_front();
					if (m_tdata !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("colour mismatch: expected %0d, got %0d", want, m_tdata);
					end
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic queue_point(logic [31:0] re, logic [31:0] im);
		pending_points.push_back({im, re});
	endtask

	// Random points: mostly inside the interesting region, some near the
	// cardioid cusp where escapes take long, the rest anywhere in Q4.28.
	task automatic queue_random_points(int count);
		int unsigned pick;
		logic [31:0] re;
		logic [31:0] im;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99, 0);
			if (pick < 25) begin
				re = $urandom;
				im = $urandom;
			end else if (pick < 85) begin
				re = $urandom_range(671088640, 0) - 32'd536870912;
				im = $urandom_range(671088640, 0) - 32'd335544320;
			end else begin
				re = Q_QUARTER + $urandom_range(1 << 17, 0);
				im = $urandom_range(1 << 15, 0);
				if ($urandom_range(1, 0)) im = -im;
			end
			queue_point(re, im);
		end
	endtask

	// Waits until every point has been sent and every colour returned.
	task automatic drain();
		while (pending_points.size() != 0 || expected_colors.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_depth(logic [mbe_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_we        <= 1'b1;
		cfg_wdata     <= value;
		depth_setting = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Test sequence.
	initial begin : sequencer
		logic [mbe_pkg::CFG_W-1:0] phase_depths[8];
		phase_depths = '{16'd1, 16'd2, 16'd5, 16'd20, 16'd64, 16'd100, 16'd256,
			16'($urandom_range(40, 3))};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset depth: the origin stays bounded; the extremes escape at once.
		queue_point(Q_ZERO, Q_ZERO);
		queue_point(Q_MIN, Q_MIN);
		queue_point(Q_MAX, Q_MAX);
		queue_point(Q_MIN, Q_MAX);
		queue_point(Q_MAX, Q_MIN);
		queue_point(Q_TWO, Q_ZERO);
		queue_point(Q_ZERO, Q_TWO);
		drain();

		// Zero depth: no pass runs at all.
		write_depth(16'd0);
		queue_point(Q_ZERO, Q_ZERO);
		queue_point(Q_MAX, Q_MAX);
		queue_point(Q_MIN, Q_ZERO);
		drain();

		// Largest depth, with points that escape early.
		write_depth(16'hFFFF);
		queue_point(Q_0P3, Q_ZERO);
		queue_point(Q_NEG_3Q, Q_0P1);
		queue_point(Q_ZERO, Q_MIN);
		drain();

		// Deep enough for escapes past the 255 wrap and for periodic orbits.
		write_depth(16'd1000);
		queue_point(32'd67138392, Q_ZERO);
		queue_point(32'd67119064, Q_ZERO);
		queue_point(Q_NEG_3Q, Q_0P01);
		queue_point(Q_NEG_TWO, Q_ZERO);
		queue_point(Q_ZERO, Q_ONE);
		queue_point(Q_NEG_ONE, Q_ZERO);
		drain();

		// Random points under a range of depths; one phase runs without stalls.
		for (int p = 0; p < 8; p++) begin
			write_depth(phase_depths[p]);
			stalls_enabled = (p != 4);
			@(posedge clk);
			queue_random_points(POINTS_PER_PHASE);
			drain();
		end

		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/mbe_pkg.sv
sv/mbe_ctrl.sv
sv/mbe_datapath.sv
sv/mandelbrot_escape_time_core.sv
tb/sv/testbench.sv
